// File: sv/mfps_pkg.sv
// ============================================================================
// mfps_pkg
// Shared constants, opcode names and controller/datapath bundles for the
// unit-capacity max flow and path split unit.
// ============================================================================
package mfps_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VTX_W        = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W       = 2 * VIDX_W;
    localparam int CAP_W        = 2;
    localparam int CELL_W       = CAP_W + 1;
    localparam int FLOW_W       = 8;
    localparam int KIND_W       = 2;
    localparam int CFG_W        = 9;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

    // Controller to datapath: one bit per datapath action.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic add_edge;
        logic bfs_init;
        logic pop;
        logic load_u;
        logic scan_rd;
        logic scan_ck;
        logic aug_init;
        logic a2_init;
        logic par_rd;
        logic prev_rd;
        logic a1_min;
        logic rev_rd;
        logic wr_rev;
        logic wr_fwd;
        logic flow_add;
        logic solve_end;
        logic walk_init;
        logic walk_rd;
        logic walk_ck;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last;
        logic q_empty;
        logic hit;
        logic v_is_n;
        logic prev_is_src;
        logic flow_full;
        logic paths_zero;
        logic walk_hit;
    } t_sts;

endpackage

// File: sv/unit_max_flow_path_split_unit.sv
// ============================================================================
// unit_max_flow_path_split_unit
// Unit-capacity max flow by breadth-first augmentation, followed by a greedy
// split of the flow into source-to-sink paths, one vertex per transaction.
// ============================================================================
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  command   | start, busy         | i_kind, i_from_vertex, i_to_vertex
//  result    | o_strobe (1 cycle)  | o_flow_total, o_path_vertex, o_path_end,
//            |                     | o_all_done
//  config    | i_cfg_we            | i_cfg_wdata (vertex count)
//
//  Timing: an edge load, an ignored command or a next-vertex command with no
//  path left goes straight to the result. Any other next-vertex command scans
//  the row of the current walk vertex, one cell at a time, until it finds a
//  path edge or reaches the sink. A solve runs one search per augmenting path;
//  each dequeued vertex scans its row up to the clamped vertex count (one
//  residual-matrix read port, one read per cell), and each path found adds
//  two walks back along its edges.
//  Reset: synchronous, active low. After reset the residual matrix is cleared
//  one cell per cycle, with busy high.
//  Stalls: the receiver cannot stall; each result is shown for one cycle.
//
module unit_max_flow_path_split_unit
    import mfps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [VTX_W-1:0]  i_from_vertex,
    input  logic [VTX_W-1:0]  i_to_vertex,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [FLOW_W-1:0] o_flow_total,
    output logic [VTX_W-1:0]  o_path_vertex,
    output logic              o_path_end,
    output logic              o_all_done
);

    // Command and status between the sequencer and the datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: owns busy and the result strobe
    mfps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    // Datapath: residual matrix, search stores, flow and walk state
    mfps_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .o_flow_total  (o_flow_total),
        .o_path_vertex (o_path_vertex),
        .o_path_end    (o_path_end),
        .o_all_done    (o_all_done)
    );

`ifndef NO_ASSERTIONS
    // An accepted transaction keeps the unit busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result is shown only while busy, and the unit frees up right after.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy ##1 !busy))
        else $error("result strobe outside a busy window");

    // A path end always names a real vertex.
    a_end_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_path_end) |-> (o_path_vertex != '0))
        else $error("path end without a vertex");

    // The last vertex of the last path leaves no paths outstanding only then.
    a_done_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_path_vertex != '0) && !o_path_end) |-> !o_all_done)
        else $error("walk in progress reported as done");
`endif

endmodule

// File: sv/mfps_datapath.sv
// ============================================================================
// mfps_datapath
// Residual matrix, search parent/queue stores, walk and flow registers.
// ============================================================================
module mfps_datapath
    import mfps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [VTX_W-1:0]  i_from_vertex,
    input  logic [VTX_W-1:0]  i_to_vertex,
    output logic [FLOW_W-1:0] o_flow_total,
    output logic [VTX_W-1:0]  o_path_vertex,
    output logic              o_path_end,
    output logic              o_all_done
);

    function automatic logic [ADDR_W-1:0] f_cell(input logic [VTX_W-1:0] u,
                                                 input logic [VTX_W-1:0] v);
        logic [VTX_W-1:0] um;
        logic [VTX_W-1:0] vm;
        begin
            um = u - 1'b1;
            vm = v - 1'b1;
            return {um[VIDX_W-1:0], vm[VIDX_W-1:0]};
        end
    endfunction

    localparam logic [VTX_W-1:0]  V_ONE   = VTX_W'(1);
    localparam logic [VTX_W-1:0]  V_TWO   = VTX_W'(2);
    localparam logic [VTX_W-1:0]  V_MAX   = VTX_W'(MAX_VERTICES);
    localparam logic [CELL_W-1:0] NEW_EDGE = {1'b1, CAP_W'(1)};

    // Memories
    logic [CELL_W-1:0] r_cap_mem [MAX_VERTICES*MAX_VERTICES];
    logic [VTX_W-1:0]  r_par_mem [MAX_VERTICES];
    logic [VIDX_W-1:0] r_q_mem   [MAX_VERTICES];

    logic [CELL_W-1:0] r_mdata;
    logic [VTX_W-1:0]  r_pdata;
    logic [VIDX_W-1:0] r_qdata;

    logic [CFG_W-1:0]  r_vc;
    logic [ADDR_W-1:0] r_clr;
    logic [FLOW_W-1:0] r_flow;
    logic [FLOW_W-1:0] r_paths;
    logic [VTX_W-1:0]  r_walk;
    logic [VTX_W-1:0]  r_pv;
    logic              r_pe;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [VTX_W-1:0]  r_head;
    logic [VTX_W-1:0]  r_tail;
    logic [VTX_W-1:0]  r_u;
    logic [VTX_W-1:0]  r_v;
    logic [VTX_W-1:0]  r_cur;
    logic [VTX_W-1:0]  r_prev;
    logic [CAP_W-1:0]  r_amt;
    logic [CELL_W-1:0] r_fwd;

    logic [VTX_W-1:0]  w_sink;
    logic [VTX_W-1:0]  w_vm;
    logic [VTX_W-1:0]  w_curm;
    logic              w_hit;
    logic              w_walk_hit;
    logic              w_v_is_n;
    logic              w_edge_ok;
    logic [ADDR_W-1:0] w_ra;
    logic [ADDR_W-1:0] w_wa;
    logic [CELL_W-1:0] w_wd;
    logic              w_we;
    logic [CAP_W:0]    w_back;
    logic [CAP_W-1:0]  w_back_sat;
    logic [FLOW_W:0]   w_flow_sum;

    always_comb begin
        if (r_vc < CFG_W'(2)) begin
            w_sink = V_TWO;
        end else if (r_vc > CFG_W'(MAX_VERTICES)) begin
            w_sink = V_MAX;
        end else begin
            w_sink = VTX_W'(r_vc);
        end
    end

    assign w_vm       = r_v - 1'b1;
    assign w_curm     = r_cur - 1'b1;
    assign w_v_is_n   = (r_v == w_sink);
    assign w_hit      = !r_visited[w_vm[VIDX_W-1:0]] && (r_mdata[CAP_W-1:0] != '0);
    assign w_walk_hit = r_mdata[CAP_W] && (r_mdata[CAP_W-1:0] == '0);
    assign w_edge_ok  = (i_from_vertex != '0) && (i_to_vertex != '0) &&
                        (i_from_vertex <= V_MAX) && (i_to_vertex <= V_MAX);
    assign w_back     = {1'b0, r_mdata[CAP_W-1:0]} + {1'b0, r_amt};
    assign w_back_sat = w_back[CAP_W] ? '1 : w_back[CAP_W-1:0];
    assign w_flow_sum = {1'b0, r_flow} + FLOW_W'(r_amt);

    // Residual matrix port selection
    always_comb begin
        w_ra = '0;
        if (i_cmd.scan_rd) begin
            w_ra = f_cell(r_u, r_v);
        end else if (i_cmd.prev_rd) begin
            w_ra = f_cell(r_pdata, r_cur);
        end else if (i_cmd.rev_rd) begin
            w_ra = f_cell(r_cur, r_prev);
        end else if (i_cmd.walk_rd) begin
            w_ra = f_cell(r_walk, r_v);
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
            w_wa = r_clr;
        end else if (i_cmd.add_edge) begin
            w_we = w_edge_ok;
            w_wa = f_cell(i_from_vertex, i_to_vertex);
            w_wd = NEW_EDGE;
        end else if (i_cmd.wr_rev) begin
            w_we = 1'b1;
            w_wa = f_cell(r_cur, r_prev);
            w_wd = {r_mdata[CAP_W], w_back_sat};
        end else if (i_cmd.wr_fwd) begin
            w_we = 1'b1;
            w_wa = f_cell(r_prev, r_cur);
            w_wd = {r_fwd[CAP_W], r_fwd[CAP_W-1:0] - r_amt};
        end else if (i_cmd.walk_ck) begin
            w_we = w_walk_hit;
            w_wa = f_cell(r_walk, r_v);
            w_wd = NEW_EDGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cap_mem[w_wa] <= w_wd;
        end
        r_mdata <= r_cap_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_ck && w_hit) begin
            r_par_mem[w_vm[VIDX_W-1:0]] <= r_u;
        end
        if (i_cmd.par_rd) begin
            r_pdata <= r_par_mem[w_curm[VIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bfs_init) begin
            r_q_mem[0] <= '0;
        end else if (i_cmd.scan_ck && w_hit && !w_v_is_n && (r_tail < V_MAX)) begin
            r_q_mem[r_tail[VIDX_W-1:0]] <= w_vm[VIDX_W-1:0];
        end
        r_qdata <= r_q_mem[r_head[VIDX_W-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc    <= CFG_W'(2);
            r_clr   <= '0;
            r_flow  <= '0;
            r_paths <= '0;
            r_walk  <= V_ONE;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.flow_add) begin
                r_flow <= w_flow_sum[FLOW_W] ? '1 : w_flow_sum[FLOW_W-1:0];
            end
            if (i_cmd.solve_end) begin
                r_paths <= r_flow;
                r_walk  <= V_ONE;
            end
            if (i_cmd.walk_ck) begin
                if (w_walk_hit) begin
                    if (w_v_is_n) begin
                        r_paths <= r_paths - 1'b1;
                        r_walk  <= V_ONE;
                    end else begin
                        r_walk <= r_v;
                    end
                end else if (w_v_is_n) begin
                    r_paths <= '0;
                    r_walk  <= V_ONE;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pv <= '0;
            r_pe <= 1'b0;
        end
        if (i_cmd.walk_ck && w_walk_hit) begin
            r_pv <= r_v;
            r_pe <= w_v_is_n;
        end
        if (i_cmd.bfs_init) begin
            r_visited <= MAX_VERTICES'(1);
            r_head    <= '0;
            r_tail    <= V_ONE;
        end
        if (i_cmd.pop) begin
            r_head <= r_head + 1'b1;
        end
        if (i_cmd.load_u) begin
            r_u <= {1'b0, r_qdata} + V_ONE;
            r_v <= V_ONE;
        end
        if (i_cmd.walk_init) begin
            r_v <= V_ONE;
        end
        if (i_cmd.scan_ck || i_cmd.walk_ck) begin
            r_v <= r_v + 1'b1;
        end
        if (i_cmd.scan_ck && w_hit) begin
            r_visited[w_vm[VIDX_W-1:0]] <= 1'b1;
            if (!w_v_is_n && (r_tail < V_MAX)) begin
                r_tail <= r_tail + 1'b1;
            end
        end
        if (i_cmd.aug_init) begin
            r_cur <= w_sink;
            r_amt <= '1;
        end
        if (i_cmd.a2_init) begin
            r_cur <= w_sink;
        end
        if (i_cmd.prev_rd) begin
            r_prev <= r_pdata;
        end
        if (i_cmd.a1_min) begin
            if (r_mdata[CAP_W-1:0] < r_amt) begin
                r_amt <= r_mdata[CAP_W-1:0];
            end
            r_cur <= r_prev;
        end
        if (i_cmd.rev_rd) begin
            r_fwd <= r_mdata;
        end
        if (i_cmd.wr_fwd) begin
            r_cur <= r_prev;
        end
    end

    assign o_sts.clr_last    = (r_clr == '1);
    assign o_sts.q_empty     = (r_head == r_tail);
    assign o_sts.hit         = w_hit;
    assign o_sts.v_is_n      = w_v_is_n;
    assign o_sts.prev_is_src = (r_prev == V_ONE);
    assign o_sts.flow_full   = (r_flow == '1);
    assign o_sts.paths_zero  = (r_paths == '0);
    assign o_sts.walk_hit    = w_walk_hit;

    assign o_flow_total  = r_flow;
    assign o_path_vertex = r_pv;
    assign o_path_end    = r_pe;
    assign o_all_done    = (r_paths == '0);

endmodule

// File: sv/mfps_ctrl.sv
// ============================================================================
// mfps_ctrl
// Sequencer for clearing, edge load, augmenting search and path walk.
// ============================================================================
module mfps_ctrl
    import mfps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] i_kind,
    input  t_sts              i_sts,
    output t_cmd              o_cmd,
    output logic              busy,
    output logic              o_strobe
);

    localparam logic [4:0] S_CLR       = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_SOLVE_CHK = 5'd2;
    localparam logic [4:0] S_BFS_INIT  = 5'd3;
    localparam logic [4:0] S_POP       = 5'd4;
    localparam logic [4:0] S_LOAD_U    = 5'd5;
    localparam logic [4:0] S_SCAN_RD   = 5'd6;
    localparam logic [4:0] S_SCAN_CK   = 5'd7;
    localparam logic [4:0] S_AUG_INIT  = 5'd8;
    localparam logic [4:0] S_A1_PAR    = 5'd9;
    localparam logic [4:0] S_A1_PREV   = 5'd10;
    localparam logic [4:0] S_A1_MIN    = 5'd11;
    localparam logic [4:0] S_A2_INIT   = 5'd12;
    localparam logic [4:0] S_A2_PAR    = 5'd13;
    localparam logic [4:0] S_A2_PREV   = 5'd14;
    localparam logic [4:0] S_A2_REV    = 5'd15;
    localparam logic [4:0] S_A2_WREV   = 5'd16;
    localparam logic [4:0] S_A2_WFWD   = 5'd17;
    localparam logic [4:0] S_FLOW_ADD  = 5'd18;
    localparam logic [4:0] S_SOLVE_END = 5'd19;
    localparam logic [4:0] S_WALK_INIT = 5'd20;
    localparam logic [4:0] S_WALK_RD   = 5'd21;
    localparam logic [4:0] S_WALK_CK   = 5'd22;
    localparam logic [4:0] S_RESP      = 5'd23;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    case (i_kind)
                        KIND_ADD: begin
                            o_cmd.add_edge = 1'b1;
                            n_state = S_RESP;
                        end
                        KIND_SOLVE: n_state = S_SOLVE_CHK;
                        KIND_NEXT:  n_state = i_sts.paths_zero ? S_RESP : S_WALK_INIT;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_SOLVE_CHK: n_state = i_sts.flow_full ? S_SOLVE_END : S_BFS_INIT;
            S_BFS_INIT: begin
                o_cmd.bfs_init = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_state = S_SOLVE_END;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_LOAD_U;
                end
            end
            S_LOAD_U: begin
                o_cmd.load_u = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                o_cmd.scan_ck = 1'b1;
                if (i_sts.hit && i_sts.v_is_n) begin
                    n_state = S_AUG_INIT;
                end else if (i_sts.v_is_n) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_AUG_INIT: begin
                o_cmd.aug_init = 1'b1;
                n_state = S_A1_PAR;
            end
            S_A1_PAR: begin
                o_cmd.par_rd = 1'b1;
                n_state = S_A1_PREV;
            end
            S_A1_PREV: begin
                o_cmd.prev_rd = 1'b1;
                n_state = S_A1_MIN;
            end
            S_A1_MIN: begin
                o_cmd.a1_min = 1'b1;
                n_state = i_sts.prev_is_src ? S_A2_INIT : S_A1_PAR;
            end
            S_A2_INIT: begin
                o_cmd.a2_init = 1'b1;
                n_state = S_A2_PAR;
            end
            S_A2_PAR: begin
                o_cmd.par_rd = 1'b1;
                n_state = S_A2_PREV;
            end
            S_A2_PREV: begin
                o_cmd.prev_rd = 1'b1;
                n_state = S_A2_REV;
            end
            S_A2_REV: begin
                o_cmd.rev_rd = 1'b1;
                n_state = S_A2_WREV;
            end
            S_A2_WREV: begin
                o_cmd.wr_rev = 1'b1;
                n_state = S_A2_WFWD;
            end
            S_A2_WFWD: begin
                o_cmd.wr_fwd = 1'b1;
                n_state = i_sts.prev_is_src ? S_FLOW_ADD : S_A2_PAR;
            end
            S_FLOW_ADD: begin
                o_cmd.flow_add = 1'b1;
                n_state = S_SOLVE_CHK;
            end
            S_SOLVE_END: begin
                o_cmd.solve_end = 1'b1;
                n_state = S_RESP;
            end
            S_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = S_WALK_RD;
            end
            S_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state = S_WALK_CK;
            end
            S_WALK_CK: begin
                o_cmd.walk_ck = 1'b1;
                if (i_sts.walk_hit || i_sts.v_is_n) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_RESP);

endmodule
